/* design/cfbm_pkg.sv */
// Shared widths, codes, types and period helpers for the cassette FSK byte modulator.
package cfbm_pkg;

   localparam int RATE_W       = 17;
   localparam int AMP_W        = 15;
   localparam int FUNC_W       = 2;
   localparam int BYTE_W       = 8;
   localparam int CYCLES_W     = 16;
   localparam int SAMPLE_W     = 16;
   localparam int PERIOD_W     = 8;
   localparam int HALF_W       = 7;
   localparam int POS_W        = 4;
   localparam int FRAME_W      = 10;
   localparam int CSR_ADDR_W   = 1;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_RATE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AMPLITUDE   = 1'd1;

   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TONE = 2'd2;

   localparam logic [RATE_W-1:0] RESET_SAMPLE_RATE = 17'd44100;
   localparam logic [AMP_W-1:0]  RESET_AMPLITUDE   = 15'd32767;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD_1K = PERIOD_W'(RESET_SAMPLE_RATE / 1000);

   // floor(x / 1000) = (x * ceil(2^27 / 1000)) >> 27 for all 17-bit x
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 18;
   localparam logic [RECIP_W-1:0] RECIP_1K = 18'd134218;
   localparam int PROD_W      = RATE_W + RECIP_W;

   localparam logic [POS_W-1:0]    STOP_POS      = 4'd10;
   localparam logic [CYCLES_W-1:0] CYC_ONE_BIT   = 16'd4;
   localparam logic [CYCLES_W-1:0] CYC_ZERO_HIGH = 16'd8;
   localparam logic [CYCLES_W-1:0] CYC_ZERO_LOW  = 16'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                is_sample;
      logic                rejected;
      logic                idle;
   } rsp_type;

   typedef struct packed {
      logic                active;
      logic [POS_W-1:0]    pos;
      logic                low;
      logic [CYCLES_W-1:0] cycles;
      logic [HALF_W-1:0]   samples;
   } part_type;

   function automatic logic [PERIOD_W-1:0] period_1k(input logic [RATE_W-1:0] rate);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(rate) * PROD_W'(RECIP_1K);
      return prod[RECIP_SHIFT +: PERIOD_W];
   endfunction

   function automatic logic [HALF_W-1:0] half_up(input logic [PERIOD_W-1:0] p);
      logic [PERIOD_W:0] sum;
      sum = {1'b0, p} + (PERIOD_W+1)'(1);
      return sum[HALF_W:1];
   endfunction

   function automatic logic [HALF_W-1:0] half_dn(input logic [PERIOD_W-1:0] p);
      return p[HALF_W:1];
   endfunction

endpackage

/* design/cassette_fsk_byte_modulator.sv */
// Cassette FSK byte modulator: square-wave tape tones, one sample per tick beat.
//
//  channel  | dir | beat carries
//  ---------+-----+---------------------------------------------------------
//  req_     | in  | tuser: func; tdata: byte_value, tone_high, tone_cycles
//  rsp_     | out | tuser: is_sample; tdata: sample, rejected, idle
//  csr_     | in  | write only: sample_rate (index 0), amplitude (index 1)
//
//  One request beat per cycle, one response beat per request, registered and valid in the next cycle.
//  Throughput is set by the single state update per beat; the response
//  register drains while the next request is taken.
//  A stalled rsp_ side holds req_tready low only while the response register
//  is full and not being taken. Reset is synchronous and returns to idle with
//  sample_rate 44100 and amplitude 32767.
module cassette_fsk_byte_modulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] byte_value, [8] tone_high, [24:9] tone_cycles, rest zero
   input  logic [cfbm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] func
   input  logic [cfbm_pkg::FUNC_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] sample, [16] rejected, [17] idle, rest zero
   output logic [cfbm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] is_sample
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [cfbm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [cfbm_pkg::RATE_W-1:0]        csr_wdata
);
   import cfbm_pkg::*;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_BYTE = 2'd1;
   localparam logic [1:0] MODE_TONE = 2'd2;

   logic [PERIOD_W-1:0] period_lo_ff, period_lo_in;
   logic [AMP_W-1:0]    amp_ff, amp_in;
   logic [PERIOD_W-1:0] period_hi;

   logic [1:0]          mode_ff, mode_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                low_ff, low_in;
   logic [CYCLES_W-1:0] cycles_left_ff, cycles_left_in;
   logic                second_ff, second_in;
   logic [HALF_W-1:0]   samples_left_ff, samples_left_in;
   logic                tone_hi_ff, tone_hi_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_accept;
   logic [FUNC_W-1:0]   func;
   logic [BYTE_W-1:0]   byte_value;
   logic                tone_high;
   logic [CYCLES_W-1:0] tone_cycles;
   logic [SAMPLE_W-1:0] amp16;
   logic [PERIOD_W-1:0] period_cur;
   logic [PERIOD_W-1:0] period_tone;
   logic [FRAME_W-1:0]  load_frame;
   part_type            load_part;
   part_type            next_part;
   logic [POS_W-1:0]    adv_pos;
   logic                adv_low;
   logic [HALF_W-1:0]   samples_dec;
   logic [CYCLES_W-1:0] cycles_dec;

   // Finds the next playable part of a byte frame from the given position.
   function automatic part_type seek_part(input logic [FRAME_W-1:0]  frame,
                                          input logic [POS_W-1:0]    pos,
                                          input logic                low,
                                          input logic [PERIOD_W-1:0] p_lo);
      part_type             r;
      logic [(1<<POS_W)-1:0] frame_ext;
      logic [PERIOD_W-1:0]  p_hi;
      p_hi      = p_lo >> 1;
      frame_ext = (1<<POS_W)'(frame);
      r.pos     = pos;
      r.low     = low;
      r.active  = (pos < STOP_POS) && (p_lo != '0);
      if (!low && p_hi == '0) begin
         r.low = 1'b1;
      end
      if (frame_ext[pos]) begin
         r.cycles = CYC_ONE_BIT;
      end else begin
         r.cycles = r.low ? CYC_ZERO_LOW : CYC_ZERO_HIGH;
      end
      r.samples = half_up(r.low ? p_lo : p_hi);
      return r;
   endfunction

   assign func        = req_tuser;
   assign byte_value  = req_tdata[BYTE_W-1:0];
   assign tone_high   = req_tdata[BYTE_W];
   assign tone_cycles = req_tdata[BYTE_W+1 +: CYCLES_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign period_hi   = period_lo_ff >> 1;
   assign period_cur  = tone_hi_ff ? period_hi : period_lo_ff;
   assign period_tone = tone_high ? period_hi : period_lo_ff;
   assign amp16       = SAMPLE_W'(amp_ff);
   assign load_frame  = {1'b1, byte_value, 1'b0};
   assign load_part   = seek_part(load_frame, '0, 1'b0, period_lo_ff);
   assign adv_low     = !low_ff;
   assign adv_pos     = low_ff ? pos_ff + POS_W'(1) : pos_ff;
   assign next_part   = seek_part(frame_ff, adv_pos, adv_low, period_lo_ff);
   assign samples_dec = samples_left_ff - HALF_W'(1);
   assign cycles_dec  = cycles_left_ff - CYCLES_W'(1);

   always_comb begin
      period_lo_in = period_lo_ff;
      amp_in       = amp_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SAMPLE_RATE: period_lo_in = period_1k(csr_wdata);
            CSR_AMPLITUDE:   amp_in       = csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in         = mode_ff;
      frame_in        = frame_ff;
      pos_in          = pos_ff;
      low_in          = low_ff;
      cycles_left_in  = cycles_left_ff;
      second_in       = second_ff;
      samples_left_in = samples_left_ff;
      tone_hi_in      = tone_hi_ff;
      rsp_in.sample    = '0;
      rsp_in.is_sample = 1'b0;
      rsp_in.rejected  = 1'b0;

      priority if (func == FUNC_TICK) begin
         rsp_in.is_sample = 1'b1;
         if (mode_ff != MODE_IDLE) begin
            rsp_in.sample = second_ff ? (SAMPLE_W'(0) - amp16) : amp16;
            if (samples_dec != '0) begin
               samples_left_in = samples_dec;
            end else if (!second_ff && half_dn(period_cur) != '0) begin
               second_in       = 1'b1;
               samples_left_in = half_dn(period_cur);
            end else begin
               cycles_left_in = cycles_dec;
               // a period that dropped to zero ends the current part
               if (cycles_dec != '0 && period_cur != '0) begin
                  second_in       = 1'b0;
                  samples_left_in = half_up(period_cur);
               end else if (mode_ff == MODE_BYTE) begin
                  pos_in = next_part.pos;
                  low_in = next_part.low;
                  if (next_part.active) begin
                     tone_hi_in      = !next_part.low;
                     cycles_left_in  = next_part.cycles;
                     second_in       = 1'b0;
                     samples_left_in = next_part.samples;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
         end
      end else if (func == FUNC_BYTE || func == FUNC_TONE) begin
         if (mode_ff != MODE_IDLE) begin
            rsp_in.rejected = 1'b1;
         end else if (func == FUNC_BYTE) begin
            frame_in = load_frame;
            pos_in   = load_part.pos;
            low_in   = load_part.low;
            if (load_part.active) begin
               mode_in         = MODE_BYTE;
               tone_hi_in      = !load_part.low;
               cycles_left_in  = load_part.cycles;
               second_in       = 1'b0;
               samples_left_in = load_part.samples;
            end
         end else if (tone_cycles != '0 && period_tone != '0) begin
            mode_in         = MODE_TONE;
            tone_hi_in      = tone_high;
            cycles_left_in  = tone_cycles;
            second_in       = 1'b0;
            samples_left_in = half_up(period_tone);
         end
      end else begin
      end

      rsp_in.idle = (mode_in == MODE_IDLE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_lo_ff <= RESET_PERIOD_1K;
         amp_ff       <= RESET_AMPLITUDE;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_lo_ff <= period_lo_in;
         amp_ff       <= amp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            mode_ff <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         frame_ff        <= frame_in;
         pos_ff          <= pos_in;
         low_ff          <= low_in;
         cycles_left_ff  <= cycles_left_in;
         second_ff       <= second_in;
         samples_left_ff <= samples_left_in;
         tone_hi_ff      <= tone_hi_in;
         rsp_ff          <= rsp_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ff.is_sample;
   assign rsp_tdata    = RSP_TDATA_W'({rsp_ff.idle, rsp_ff.rejected, rsp_ff.sample});

   // active playback always has a sample pending in the current half
   a_active_samples: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (samples_left_ff != '0))
      else $error("active with no samples left");

   // a running part always has a cycle to play
   a_active_cycles: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (cycles_left_ff != '0))
      else $error("active with no cycles left");

   // byte playback never runs past the stop bit
   a_byte_pos: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_BYTE) |-> (pos_ff < STOP_POS))
      else $error("byte position past stop bit");

   // a command taken while idle is never reported as rejected
   a_no_false_reject: assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode_ff == MODE_IDLE) |=> !rsp_ff.rejected)
      else $error("command rejected while idle");

   // only ticks produce nonzero samples
   a_cmd_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && func != FUNC_TICK) |=> (rsp_ff.sample == '0))
      else $error("nonzero sample on a command beat");

endmodule

/* tb/cassette_fsk_byte_modulator_test.sv */
// Self-checking testbench for the cassette FSK byte modulator stream block.
`timescale 1ns / 100ps

module cassette_fsk_byte_modulator_test;
   import cfbm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 850;

   localparam rsp_type RSP_SILENT_TICK = '{16'h0000, 1'b1, 1'b0, 1'b1};
   localparam rsp_type RSP_NO_RUN      = '{16'h0000, 1'b0, 1'b0, 1'b1};
   localparam rsp_type RSP_TAKEN       = '{16'h0000, 1'b0, 1'b0, 1'b0};
   localparam rsp_type RSP_BUSY        = '{16'h0000, 1'b0, 1'b1, 1'b0};
   localparam rsp_type RSP_PEAK        = '{16'h7FFF, 1'b1, 1'b0, 1'b0};
   localparam rsp_type RSP_NONE        = '0;

   typedef enum logic [1:0] {MOD_IDLE, MOD_BYTE, MOD_TONE} mod_state_type;

   typedef struct packed {
      bit                  load_cfg;
      logic [RATE_W-1:0]   rate;
      logic [AMP_W-1:0]    amp;
      logic [FUNC_W-1:0]   func;
      logic [BYTE_W-1:0]   byte_val;
      logic                tone_hi;
      logic [CYCLES_W-1:0] cycles;
      bit                  has_lit;
      rsp_type             lit;
      bit                  settle;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]      req_tuser = FUNC_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = CSR_SAMPLE_RATE;
   logic [RATE_W-1:0]      csr_wdata = '0;

   cassette_fsk_byte_modulator dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // modulator state as predicted
   logic [RATE_W-1:0]   cfg_rate = 17'd44100;
   logic [AMP_W-1:0]    cfg_amp = 15'd32767;
   mod_state_type       mod_state = MOD_IDLE;
   logic [9:0]          mod_frame = '0;
   logic [3:0]          mod_bit_idx = '0;
   logic                mod_low_part = 1'b0;
   logic [15:0]         mod_cyc_cnt = '0;
   logic                mod_neg_half = 1'b0;
   logic [6:0]          mod_half_cnt = '0;
   logic                mod_hi_tone = 1'b0;

   rsp_type     predicted_audio [$];
   int unsigned n_items = 0;
   int unsigned n_errors = 0;
   int          req_next_gap = 0;
   bit          req_live = 1'b0;
   bit          req_pace = 1'b1;
   bit          rsp_hold_pending = 1'b0;
   int          quiet_cycles = 0;

   plan_row_type plan_rows [0:19] = '{
      '{1'b0, 17'd0, 15'd0, FUNC_TICK, 8'h00, 1'b0, 16'h0000, 1'b1, RSP_SILENT_TICK, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 1'b1, RSP_NO_RUN, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_TONE, 8'h00, 1'b1, 16'h0000, 1'b1, RSP_NO_RUN, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_TONE, 8'h00, 1'b1, 16'h0001, 1'b1, RSP_TAKEN, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_TONE, 8'h00, 1'b0, 16'hFFFF, 1'b1, RSP_BUSY, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_BYTE, 8'hFF, 1'b0, 16'h0000, 1'b1, RSP_BUSY, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_TICK, 8'h00, 1'b0, 16'h0000, 1'b1, RSP_PEAK, 1'b1},
      '{1'b1, 17'd1000, 15'd0, FUNC_BYTE, 8'h00, 1'b0, 16'h0000, 1'b1, RSP_TAKEN, 1'b1},
      '{1'b1, 17'd500, 15'd32767, FUNC_BYTE, 8'hA5, 1'b0, 16'h0000, 1'b1, RSP_NO_RUN, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_TONE, 8'h00, 1'b1, 16'h0005, 1'b1, RSP_NO_RUN, 1'b0},
      '{1'b0, 17'd0, 15'd0, FUNC_TICK, 8'h00, 1'b0, 16'h0000, 1'b1, RSP_SILENT_TICK, 1'b0},
      '{1'b1, 17'd1500, 15'd1, FUNC_TONE, 8'h00, 1'b0, 16'h0003, 1'b1, RSP_TAKEN, 1'b1},
      '{1'b0, 17'd0, 15'd0, FUNC_BYTE, 8'h5A, 1'b0, 16'h0000, 1'b1, RSP_TAKEN, 1'b1},
      '{1'b1, 17'd131071, 15'd32767, FUNC_TONE, 8'h00, 1'b0, 16'h0001, 1'b1, RSP_TAKEN, 1'b1},
      '{1'b1, 17'd1999, 15'd12345, FUNC_BYTE, 8'h01, 1'b0, 16'h0000, 1'b1, RSP_TAKEN, 1'b1},
      '{1'b0, 17'd0, 15'd0, FUNC_BYTE, 8'h80, 1'b0, 16'h0000, 1'b0, RSP_NONE, 1'b1},
      '{1'b1, 17'd2000, 15'd16384, FUNC_TONE, 8'h00, 1'b1, 16'h0002, 1'b0, RSP_NONE, 1'b1},
      '{1'b1, 17'd3999, 15'd32767, FUNC_BYTE, 8'hFF, 1'b0, 16'h0000, 1'b0, RSP_NONE, 1'b1},
      '{1'b1, 17'd0, 15'd0, FUNC_TICK, 8'h00, 1'b0, 16'h0000, 1'b1, RSP_SILENT_TICK, 1'b0},
      '{1'b1, 17'd44100, 15'd32767, FUNC_TONE, 8'h00, 1'b0, 16'h0001, 1'b0, RSP_NONE, 1'b1}
   };

   function automatic int unsigned tone_period(input logic hi);
      return {15'd0, cfg_rate} / (hi ? 32'd2000 : 32'd1000);
   endfunction

   function automatic bit open_part(input logic hi, input logic [15:0] cyc);
      int unsigned p;
      p = tone_period(hi);
      if (cyc == 16'd0 || p == 0) return 1'b0;
      mod_hi_tone = hi;
      mod_cyc_cnt = cyc;
      mod_neg_half = 1'b0;
      mod_half_cnt = 7'((p + 1) / 2);
      return 1'b1;
   endfunction

   function automatic void step_part();
      if (mod_low_part) begin
         mod_low_part = 1'b0;
         mod_bit_idx = mod_bit_idx + 4'd1;
      end else begin
         mod_low_part = 1'b1;
      end
   endfunction

   // skips parts whose period is zero; start bit 0, data LSB first, stop bit 1
   function automatic void find_next_part();
      logic [15:0] cyc;
      while (mod_bit_idx < 4'd10) begin
         if (mod_frame[mod_bit_idx]) cyc = 16'd4;
         else cyc = mod_low_part ? 16'd2 : 16'd8;
         if (open_part(!mod_low_part, cyc)) return;
         step_part();
      end
      mod_state = MOD_IDLE;
   endfunction

   function automatic void close_part();
      if (mod_state == MOD_BYTE) begin
         step_part();
         find_next_part();
      end else begin
         mod_state = MOD_IDLE;
      end
   endfunction

   function automatic void close_cycle();
      int unsigned first;
      mod_cyc_cnt = mod_cyc_cnt - 16'd1;
      if (mod_cyc_cnt != 16'd0) begin
         first = (tone_period(mod_hi_tone) + 1) / 2;
         if (first != 0) begin
            mod_neg_half = 1'b0;
            mod_half_cnt = 7'(first);
            return;
         end
      end
      close_part();
   endfunction

   function automatic rsp_type modulate_step(input logic [FUNC_W-1:0] f,
                                             input logic [BYTE_W-1:0] bv,
                                             input logic hi,
                                             input logic [CYCLES_W-1:0] cyc);
      rsp_type     r;
      int unsigned neg;
      r = '0;
      if (f == FUNC_TICK) begin
         r.is_sample = 1'b1;
         if (mod_state != MOD_IDLE) begin
            r.sample = mod_neg_half ? -{1'b0, cfg_amp} : {1'b0, cfg_amp};
            if (mod_half_cnt != 7'd0) mod_half_cnt = mod_half_cnt - 7'd1;
            if (mod_half_cnt == 7'd0) begin
               if (!mod_neg_half) begin
                  neg = tone_period(mod_hi_tone) / 2;
                  if (neg != 0) begin
                     mod_neg_half = 1'b1;
                     mod_half_cnt = 7'(neg);
                  end else begin
                     close_cycle();
                  end
               end else begin
                  close_cycle();
               end
            end
         end
      end else if (f == FUNC_BYTE || f == FUNC_TONE) begin
         if (mod_state != MOD_IDLE) begin
            r.rejected = 1'b1;
         end else if (f == FUNC_BYTE) begin
            mod_frame = {1'b1, bv, 1'b0};
            mod_bit_idx = 4'd0;
            mod_low_part = 1'b0;
            mod_state = MOD_BYTE;
            find_next_part();
         end else if (open_part(hi, cyc)) begin
            mod_state = MOD_TONE;
         end
      end
      r.idle = (mod_state == MOD_IDLE);
      return r;
   endfunction

   task automatic send_req(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] bv,
                           input logic hi, input logic [CYCLES_W-1:0] cyc,
                           input bit has_lit, input rsp_type lit);
      rsp_type r;
      if (req_next_gap > 0) repeat (req_next_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= REQ_TDATA_W'({cyc, hi, bv});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = modulate_step(f, bv, hi, cyc);
      predicted_audio.push_back(has_lit ? lit : r);
      n_items++;
      req_next_gap = req_pace ? $urandom_range(0, 18) : 0;
      req_live = (req_next_gap == 0);
      if (!req_live) req_tvalid <= 1'b0;
   endtask

   task automatic send_random(input logic [FUNC_W-1:0] f);
      send_req(f, 8'($urandom), 1'($urandom), 16'($urandom), 1'b0, RSP_NONE);
   endtask

   task automatic drain();
      if (req_live) begin
         req_tvalid <= 1'b0;
         req_live = 1'b0;
      end
      while (predicted_audio.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [RATE_W-1:0] rate, input logic [AMP_W-1:0] amp);
      csr_we <= 1'b1;
      csr_addr <= CSR_SAMPLE_RATE;
      csr_wdata <= rate;
      @(posedge clock);
      csr_addr <= CSR_AMPLITUDE;
      csr_wdata <= RATE_W'(amp);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_rate = rate;
      cfg_amp = amp;
   endtask

   // one command (or one to three ticks), then ticks until the run ends, with stray commands mixed in
   task automatic play_sequence();
      int pick;
      int draw;
      logic [CYCLES_W-1:0] cyc;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_random(FUNC_BYTE);
      end else if (pick < 80) begin
         draw = $urandom_range(0, 99);
         if (draw < 8) cyc = 16'd0;
         else if (draw < 85) cyc = 16'($urandom_range(1, 6));
         else cyc = 16'($urandom_range(7, 40));
         send_req(FUNC_TONE, 8'($urandom), 1'($urandom), cyc, 1'b0, RSP_NONE);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 3)) send_random(FUNC_TICK);
      end else begin
         send_random(FUNC_UNUSED);
      end
      while (mod_state != MOD_IDLE && n_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) send_random($urandom_range(0, 1) ? FUNC_BYTE : FUNC_TONE);
         else if (pick < 7) send_random(FUNC_UNUSED);
         else send_random(FUNC_TICK);
      end
   endtask

   // response side: random stalls, calm stretches, one long hold-off on request
   initial begin
      int stall;
      int run_left;
      bit calm;
      run_left = 0;
      calm = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (run_left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            run_left = 40;
         end
         run_left--;
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            stall = RSP_HOLD_CYCLES;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sample = rsp_tdata[15:0];
         got.rejected = rsp_tdata[16];
         got.idle = rsp_tdata[17];
         got.is_sample = rsp_tuser[0];
         if (predicted_audio.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("unexpected beat: sample %0d is_sample %0b rejected %0b idle %0b",
                        $signed(got.sample), got.is_sample, got.rejected, got.idle);
         end else begin
            want = predicted_audio.pop_front();
            if (got.sample !== want.sample || got.is_sample !== want.is_sample ||
                got.rejected !== want.rejected || got.idle !== want.idle) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("mismatch (sample is_sample rejected idle): exp %0d %0b %0b %0b, got %0d %0b %0b %0b",
                           $signed(want.sample), want.is_sample, want.rejected, want.idle,
                           $signed(got.sample), got.is_sample, got.rejected, got.idle);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("cassette_fsk_byte_modulator regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int unsigned phase_mark;
      bit          first_phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(plan_rows); i++) begin
         if (plan_rows[i].load_cfg) begin
            drain();
            set_config(plan_rows[i].rate, plan_rows[i].amp);
         end
         send_req(plan_rows[i].func, plan_rows[i].byte_val, plan_rows[i].tone_hi,
                  plan_rows[i].cycles, plan_rows[i].has_lit, plan_rows[i].lit);
         if (plan_rows[i].settle)
            while (mod_state != MOD_IDLE) send_random(FUNC_TICK);
      end

      phase_mark = n_items;
      first_phase = 1'b1;
      while (n_items < ITEM_TARGET) begin
         if (n_items >= phase_mark) begin
            drain();
            if ($urandom_range(0, 4) == 0)
               set_config(17'($urandom_range(4000, 12000)), 15'($urandom_range(0, 32767)));
            else
               set_config(17'($urandom_range(0, 4000)), 15'($urandom_range(0, 32767)));
            req_pace = ($urandom_range(0, 3) != 0);
            if (first_phase) begin
               // back-to-back beats against a held-off response side
               rsp_hold_pending = 1'b1;
               req_pace = 1'b0;
               first_phase = 1'b0;
            end
            phase_mark = n_items + 100;
         end
         play_sequence();
      end

      drain();
      repeat (8) @(posedge clock);
      if (n_errors == 0 && predicted_audio.size() == 0)
         $display("cassette_fsk_byte_modulator regression: pass");
      else
         $display("cassette_fsk_byte_modulator regression: fail");
      $finish;
   end

endmodule

/* files.f */
design/cfbm_pkg.sv
design/cassette_fsk_byte_modulator.sv
tb/cassette_fsk_byte_modulator_test.sv
